### hw/rtl/vmt_pkg.sv
// Shared constants and types for the vertex matrix transform unit.
package vmt_pkg;

    localparam int COEF_FRAC_BITS = 14;
    localparam int COMP_WIDTH     = 32;
    localparam int FIELD_W        = 32;
    localparam int COEF_W         = 16;
    localparam int ROW_W          = 64;
    localparam int NUM_ROWS       = 4;
    localparam int ONE_Q16        = 65536;

    // operands must also hold 1.0 in Q16.16 for the implied w
    localparam int OPND_W = (COMP_WIDTH > 17) ? COMP_WIDTH : 18;
    localparam int PROD_W = OPND_W + COEF_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam int ADDR_W = 5;

    localparam logic [1:0] REG_ROW_ONE   = 2'd0;
    localparam logic [1:0] REG_ROW_TWO   = 2'd1;
    localparam logic [1:0] REG_ROW_THREE = 2'd2;
    localparam logic [1:0] REG_ROW_FOUR  = 2'd3;

    localparam logic [ROW_W-1:0] ROW_ONE_RST   = 64'h0000_0000_0000_4000;
    localparam logic [ROW_W-1:0] ROW_TWO_RST   = 64'h0000_0000_4000_0000;
    localparam logic [ROW_W-1:0] ROW_THREE_RST = 64'h0000_4000_0000_0000;
    localparam logic [ROW_W-1:0] ROW_FOUR_RST  = 64'h4000_0000_0000_0000;

    typedef logic signed [OPND_W-1:0] opnd_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
        logic sat_en;
    } pipe_ctrl_t;

endpackage

### hw/rtl/vertex_matrix_transform_unit.sv
// Top level of the vertex matrix transform unit: APB registers and the pipeline.
//
// Row vector times 4x4 Q2.14 matrix. One vertex is taken every clock unless the
// output stalls; each beat passes the multiply, adder tree, shift and saturate
// register stages in turn (sixteen 32x16 multipliers working in parallel).
// Each stage holds its beat while the next one is full and cannot advance, so a
// waiting result does not block new input until the pipe fills. Matrix rows sit
// at APB byte addresses 0, 8, 16, 24 (64-bit data) and reset to the identity;
// write them only while no vertex is in flight.
module vertex_matrix_transform_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vmt_pkg::ADDR_W-1:0]          paddr,
    input  logic [vmt_pkg::ROW_W-1:0]           pwdata,
    output logic [vmt_pkg::ROW_W-1:0]           prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                mode,
    input  logic signed [vmt_pkg::FIELD_W-1:0]  in_x,
    input  logic signed [vmt_pkg::FIELD_W-1:0]  in_y,
    input  logic signed [vmt_pkg::FIELD_W-1:0]  in_z,
    input  logic signed [vmt_pkg::FIELD_W-1:0]  in_w,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vmt_pkg::FIELD_W-1:0]  out_x,
    output logic signed [vmt_pkg::FIELD_W-1:0]  out_y,
    output logic signed [vmt_pkg::FIELD_W-1:0]  out_z,
    output logic signed [vmt_pkg::FIELD_W-1:0]  out_w,
    output logic                                overflow
);
    import vmt_pkg::*;

    logic [ROW_W-1:0] row_reg [NUM_ROWS];
    logic [1:0]       reg_idx;
    logic             cfg_wr;

    logic             v1_reg, v2_reg, v3_reg;
    logic             v1_next, v2_next, v3_next;
    logic             mode1_reg, mode2_reg, mode3_reg;
    logic             mul_en, sum_en, sat_en;
    pipe_ctrl_t       ctrl;

    opnd_t            opnd [NUM_ROWS];
    coef_t            coef [NUM_ROWS][NUM_ROWS];
    logic signed [FIELD_W-1:0] lane_res [NUM_ROWS];
    logic             lane_sat [NUM_ROWS];

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_idx)
            REG_ROW_ONE:   prdata = row_reg[0];
            REG_ROW_TWO:   prdata = row_reg[1];
            REG_ROW_THREE: prdata = row_reg[2];
            REG_ROW_FOUR:  prdata = row_reg[3];
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_ONE_RST;
            row_reg[1] <= ROW_TWO_RST;
            row_reg[2] <= ROW_THREE_RST;
            row_reg[3] <= ROW_FOUR_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_ROW_ONE:   row_reg[0] <= pwdata;
                REG_ROW_TWO:   row_reg[1] <= pwdata;
                REG_ROW_THREE: row_reg[2] <= pwdata;
                REG_ROW_FOUR:  row_reg[3] <= pwdata;
                default:       ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // a stage advances when it is empty or the one after it advances
    assign sat_en   = !v3_reg || out_ready;
    assign sum_en   = !v2_reg || sat_en;
    assign mul_en   = !v1_reg || sum_en;
    assign in_ready = mul_en;
    assign ctrl     = '{mul_en: mul_en, sum_en: sum_en, sat_en: sat_en};

    assign v1_next = mul_en ? in_valid : v1_reg;
    assign v2_next = sum_en ? v1_reg   : v2_reg;
    assign v3_next = sat_en ? v2_reg   : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            mode1_reg <= mode;
        end
        if (sum_en)
        begin
            mode2_reg <= mode1_reg;
        end
        if (sat_en)
        begin
            mode3_reg <= mode2_reg;
        end
    end

    // ---------------- operands ----------------
    assign opnd[0] = OPND_W'(signed'(in_x[COMP_WIDTH-1:0]));
    assign opnd[1] = OPND_W'(signed'(in_y[COMP_WIDTH-1:0]));
    assign opnd[2] = OPND_W'(signed'(in_z[COMP_WIDTH-1:0]));
    assign opnd[3] = mode ? OPND_W'(ONE_Q16) : OPND_W'(signed'(in_w[COMP_WIDTH-1:0]));

    // coef[j][i]: column j, row i
    always_comb
    begin
        for (int j = 0; j < NUM_ROWS; j++)
        begin
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                coef[j][i] = row_reg[i][COEF_W*j +: COEF_W];
            end
        end
    end

    for (genvar j = 0; j < NUM_ROWS; j++)
    begin : g_lane
        vmt_lane u_lane (
            .clk    (clk),
            .ctrl   (ctrl),
            .opnd   (opnd),
            .coef   (coef[j]),
            .result (lane_res[j]),
            .sat    (lane_sat[j])
        );
    end

    // ---------------- result ----------------
    assign out_valid = v3_reg;
    assign out_x     = lane_res[0];
    assign out_y     = lane_res[1];
    assign out_z     = lane_res[2];
    assign out_w     = mode3_reg ? '0 : lane_res[3];
    assign overflow  = lane_sat[0] || lane_sat[1] || lane_sat[2]
                    || (!mode3_reg && lane_sat[3]);

endmodule

### hw/rtl/vmt_lane.sv
// One output column: four products, adder tree, floor shift and saturation.
module vmt_lane (
    input  logic                              clk,
    input  vmt_pkg::pipe_ctrl_t               ctrl,
    input  vmt_pkg::opnd_t                    opnd [vmt_pkg::NUM_ROWS],
    input  vmt_pkg::coef_t                    coef [vmt_pkg::NUM_ROWS],
    output logic signed [vmt_pkg::FIELD_W-1:0] result,
    output logic                              sat
);
    import vmt_pkg::*;

    logic signed [PROD_W-1:0]     prod_reg [NUM_ROWS];
    logic signed [PROD_W-1:0]     prod_next [NUM_ROWS];
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [SUM_W-1:0]      sum_next;
    logic signed [SUM_W-1:0]      shifted;
    logic signed [COMP_WIDTH-1:0] clamp_next;
    logic                         sat_next;
    logic signed [COMP_WIDTH-1:0] clamp_reg;
    logic                         sat_reg;
    logic [SUM_W-COMP_WIDTH:0]    upper;

    localparam logic signed [COMP_WIDTH-1:0] MAX_VAL = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam logic signed [COMP_WIDTH-1:0] MIN_VAL = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    always_comb
    begin
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            prod_next[i] = PROD_W'(opnd[i]) * PROD_W'(coef[i]);
        end
    end

    assign sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
                    + SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]);

    // arithmetic shift is floor; saturate when the bits above the sign disagree
    assign shifted = sum_reg >>> COEF_FRAC_BITS;
    assign upper   = shifted[SUM_W-1:COMP_WIDTH-1];

    always_comb
    begin
        if ((&upper) || !(|upper))
        begin
            clamp_next = shifted[COMP_WIDTH-1:0];
            sat_next   = 1'b0;
        end
        else
        begin
            clamp_next = shifted[SUM_W-1] ? MIN_VAL : MAX_VAL;
            sat_next   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.sum_en)
        begin
            sum_reg <= sum_next;
        end
        if (ctrl.sat_en)
        begin
            clamp_reg <= clamp_next;
            sat_reg   <= sat_next;
        end
    end

    assign result = FIELD_W'(clamp_reg);
    assign sat    = sat_reg;

endmodule
